// File: hdl/wgm_pkg.sv
package wgm_pkg;

    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] ANY_ONE = 8'h3F;
    localparam logic [7:0] ANY_RUN = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_CASE     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pattern;
        logic [LEN_W-1:0]          length;
        logic                      fold;
    } cfg_t;

    // lower-case 'A'..'Z' when enabled
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: hdl/wgm_config.sv
module wgm_config (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wgm_pkg::REG_W-1:0]       cfg_data,
    output wgm_pkg::cfg_t                   cfg
);

    logic [wgm_pkg::REG_W-1:0] pat_low_reg, pat_low_next;
    logic [wgm_pkg::REG_W-1:0] pat_high_reg, pat_high_next;
    logic [wgm_pkg::LEN_W-1:0] len_reg, len_next;
    logic                      fold_reg, fold_next;

    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        fold_next     = fold_reg;
        if (cfg_we)
        begin
            unique case (wgm_pkg::cfg_reg_t'(cfg_index))
                wgm_pkg::REG_PAT_LOW:  pat_low_next  = cfg_data;
                wgm_pkg::REG_PAT_HIGH: pat_high_next = cfg_data;
                wgm_pkg::REG_PAT_LEN:  len_next      = cfg_data[wgm_pkg::LEN_W-1:0];
                wgm_pkg::REG_CASE:     fold_next     = cfg_data[0];
                default:               fold_next     = fold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= '0;
            fold_reg     <= 1'b0;
        end
        else
        begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            len_reg      <= len_next;
            fold_reg     <= fold_next;
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.length  = len_reg;
    assign cfg.fold    = fold_reg;

endmodule

// File: hdl/wgm_closure.sv
module wgm_closure #(
    parameter int N = 17
) (
    input  logic [N-1:0] active,
    input  logic [N-1:0] star,
    input  logic [N-1:0] keep,
    output logic [N-1:0] closed
);

    assign closed[0] = active[0] & keep[0];

    // ripple: an active star position also enables the next one
    for (genvar i = 1; i < N; i++)
    begin : g_chain
        assign closed[i] = (active[i] | (closed[i-1] & star[i-1])) & keep[i];
    end

endmodule

// File: hdl/wgm_step.sv
module wgm_step #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  wgm_pkg::cfg_t              cfg,
    input  logic [MAX_PATTERN_LEN:0]   state,
    input  logic [7:0]                 text_byte,
    input  logic                       end_of_text,
    output logic [MAX_PATTERN_LEN:0]   state_next,
    output logic                       matched
);

    localparam int NPOS = MAX_PATTERN_LEN + 1;
    localparam int CAP  = (MAX_PATTERN_LEN < wgm_pkg::PAT_BYTES) ?
                          MAX_PATTERN_LEN : wgm_pkg::PAT_BYTES;

    logic [wgm_pkg::LEN_W-1:0] len_used;
    logic [6:0]                len7;
    logic [7:0]                text_f;
    logic [NPOS-1:0]           keep;
    logic [NPOS-1:0]           star;
    logic [NPOS-1:0]           hit;
    logic [NPOS-1:0]           at_len;
    logic [NPOS-1:0]           closed;
    logic [NPOS-1:0]           raw;
    logic [NPOS-1:0]           raw_closed;

    assign len_used = (cfg.length > wgm_pkg::LEN_W'(CAP)) ?
                      wgm_pkg::LEN_W'(CAP) : cfg.length;
    assign len7     = {2'b00, len_used};
    assign text_f   = wgm_pkg::fold_byte(text_byte, cfg.fold);

    for (genvar i = 0; i < NPOS; i++)
    begin : g_pos
        localparam logic [6:0] IDX = 7'(i);
        logic [7:0] pbyte;
        logic       in_pat;

        if (i < wgm_pkg::PAT_BYTES)
        begin : g_byte
            assign pbyte = cfg.pattern[i];
        end
        else
        begin : g_zero
            assign pbyte = 8'h00;
        end

        assign in_pat    = IDX < len7;
        assign keep[i]   = IDX <= len7;
        assign at_len[i] = IDX == len7;
        assign star[i]   = in_pat && (pbyte == wgm_pkg::ANY_RUN);
        assign hit[i]    = in_pat && (pbyte != wgm_pkg::ANY_RUN) &&
                           ((pbyte == wgm_pkg::ANY_ONE) ||
                            (wgm_pkg::fold_byte(pbyte, cfg.fold) == text_f));

        if (i == 0)
        begin : g_first
            assign raw[i] = closed[i] & star[i];
        end
        else
        begin : g_rest
            assign raw[i] = (closed[i] & star[i]) | (closed[i-1] & hit[i-1]);
        end
    end

    wgm_closure #(.N(NPOS)) u_close_in (
        .active (state),
        .star   (star),
        .keep   (keep),
        .closed (closed)
    );

    wgm_closure #(.N(NPOS)) u_close_out (
        .active (raw),
        .star   (star),
        .keep   (keep),
        .closed (raw_closed)
    );

    assign matched    = |(closed & at_len);
    assign state_next = end_of_text ? NPOS'(1) : raw_closed;

endmodule

// File: hdl/wildcard_glob_matcher.sv
// A word is registered in the input register; for end words only, the result is then
// captured in the output register. One word per cycle is taken unless input stalls.
// The position vector is updated by one bit-parallel step with two star-closure
// ripples over MAX_PATTERN_LEN+1 positions; input stalls only when an end word
// waits behind an unread result. Reset clears the pattern registers, length and
// case fold, and leaves only position zero active.
module wildcard_glob_matcher #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] text_byte
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [0] matched, [7:1] zero
    input  logic                            cfg_we,
    input  logic [wgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wgm_pkg::REG_W-1:0]       cfg_data
);

    localparam int NPOS = MAX_PATTERN_LEN + 1;

    wgm_pkg::cfg_t   cfg;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic [NPOS-1:0] state_reg, state_next;
    logic            out_valid_reg;
    logic            out_match_reg;
    logic            step_match;
    logic            step_fire;
    logic            s_fire;

    wgm_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wgm_step #(.MAX_PATTERN_LEN(MAX_PATTERN_LEN)) u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .state_next  (state_next),
        .matched     (step_match)
    );

    // hold an end word while the result register is full and unread
    assign step_fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= NPOS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
            if (step_fire && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step_fire && in_last_reg)
        begin
            out_match_reg <= step_match;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_match_reg};

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && in_last_reg) |=> (state_reg == NPOS'(1)))
        else $error("position vector not restarted after end word");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_fire && in_last_reg))
        else $error("result raised without an end word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a blocked end word");

endmodule
